// File: sv/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// Shared constants, record layout and slot-run helpers for the video block
// allocator.
// ----------------------------------------------------------------------------
package bva_pkg;

	// geometry
	localparam int SCREENS         = 2;
	localparam int LAYERS          = 4;
	localparam int SLOTS           = 64;
	localparam int SLOTS_PER_BASE  = 8;
	localparam int MAP_SEARCH_LAST = 31;
	localparam int NUM_BASES       = SLOTS / SLOTS_PER_BASE;

	// widths
	localparam int SLOT_IW = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int BASE_W  = $clog2(NUM_BASES);
	localparam int MAP_W   = $clog2(MAP_SEARCH_LAST + 1);
	localparam int CAND_W  = (MAP_W > BASE_W) ? MAP_W : BASE_W;
	localparam int TOP_W   = 4;
	localparam int REC_DEPTH = SCREENS * LAYERS;

	// opcodes
	localparam logic [2:0] OP_RESET     = 3'd0;
	localparam logic [2:0] OP_LOAD_TILE = 3'd1;
	localparam logic [2:0] OP_LOAD_MAP  = 3'd2;
	localparam logic [2:0] OP_DEL_TILE  = 3'd3;
	localparam logic [2:0] OP_DEL_MAP   = 3'd4;

	// status codes
	localparam logic STAT_DONE     = 1'b0;
	localparam logic STAT_NO_SPACE = 1'b1;

	// slots needed per map size code
	localparam logic [2:0] MAP_NEED [4] = '{3'd1, 3'd2, 3'd2, 3'd4};

	// per screen and layer record
	typedef struct packed {
		logic [BASE_W-1:0] tile_base;
		logic [CNT_W-1:0]  tile_slots;
		logic [MAP_W-1:0]  map_start;
		logic [2:0]        map_slots;
	} rec_t;

	// search request and answer
	typedef struct packed {
		logic             start;
		logic             is_tile;
		logic [CNT_W-1:0] need;
		logic [TOP_W-1:0] top;
	} srch_ctl_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [CAND_W-1:0] idx;
	} srch_res_t;

	// mask of n slots from start, clipped at the end of the map
	function automatic logic [SLOTS-1:0] run_mask(input logic [SLOT_IW-1:0] start,
		input logic [CNT_W-1:0] n);
		logic [SLOTS-1:0] one;
		logic [SLOTS-1:0] lo;
		one = {{(SLOTS-1){1'b0}}, 1'b1};
		lo  = (one << n) - one;
		return lo << start;
	endfunction

endpackage

// File: sv/bva_ram.sv
// ----------------------------------------------------------------------------
// bva_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/bva_search.sv
// ----------------------------------------------------------------------------
// bva_search
// Free-run search unit: tests one candidate start per cycle against the
// held slot map, tile bases downward from the top, map starts upward from 0.
// ----------------------------------------------------------------------------
module bva_search (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bva_pkg::srch_ctl_t        ctl,
	input  logic [bva_pkg::SLOTS-1:0] map,
	output bva_pkg::srch_res_t        res
);

	logic                           act_q;
	logic                           is_tile_q;
	logic [bva_pkg::CNT_W-1:0]      need_q;
	logic [bva_pkg::CAND_W-1:0]     cand_q;
	bva_pkg::srch_res_t             res_q;

	logic [bva_pkg::SLOT_IW-1:0]    cand_start;
	logic [bva_pkg::CNT_W:0]        run_end;
	logic                           fits;
	logic                           free;
	logic                           last;

	// candidate test
	always_comb begin
		cand_start = is_tile_q ?
			bva_pkg::SLOT_IW'(cand_q * bva_pkg::SLOTS_PER_BASE) :
			bva_pkg::SLOT_IW'(cand_q);
		run_end = (bva_pkg::CNT_W + 1)'(cand_start) + (bva_pkg::CNT_W + 1)'(need_q);
		fits    = run_end <= (bva_pkg::CNT_W + 1)'(bva_pkg::SLOTS);
		free    = fits && ((map & bva_pkg::run_mask(cand_start, need_q)) == '0);
		last    = is_tile_q ? (cand_q == '0) :
			(cand_q == bva_pkg::CAND_W'(bva_pkg::MAP_SEARCH_LAST));
	end

	// candidate walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			is_tile_q <= 1'b0;
			need_q    <= '0;
			cand_q    <= '0;
			res_q     <= '0;
		end else begin
			if (ctl.start) begin
				is_tile_q <= ctl.is_tile;
				need_q    <= ctl.need;
				if (ctl.is_tile && ctl.top == '0) begin
					// no base to try
					res_q <= '{done: 1'b1, found: 1'b0, idx: '0};
				end else begin
					act_q  <= 1'b1;
					cand_q <= ctl.is_tile ? bva_pkg::CAND_W'(ctl.top - 1'b1) : '0;
					res_q  <= '0;
				end
			end else if (act_q) begin
				if (free) begin
					act_q <= 1'b0;
					res_q <= '{done: 1'b1, found: 1'b1, idx: cand_q};
				end else if (last) begin
					act_q <= 1'b0;
					res_q <= '{done: 1'b1, found: 1'b0, idx: '0};
				end else begin
					cand_q <= is_tile_q ? cand_q - 1'b1 : cand_q + 1'b1;
					res_q  <= '0;
				end
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res = res_q;

endmodule

// File: sv/video_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// video_block_allocator_unit
// Per-screen slot map and per-layer tile/map records held in small RAMs;
// each request reads them, releases the old run, searches (loads only), and writes back.
//
//   channel   dir  handshake              payload
//   in        in   in_valid / in_ready    opcode screen_sel layer tile_bytes
//                                         map_size_code
//   out       out  out_valid / out_ready  status base_index blocks_taken
//   cfg       in   cfg_wr_en              cfg_wr_data (tile_search_top)
//
// One item at a time: accept, read and release, then for loads a search, then
// write-back. A load tries candidates in turn: up to 8 bases for load tiles,
// up to 32 start slots for load map (search unit).
// Reset leaves all slots free and all records empty through valid bits.
// A full output register holds the write-back until the beat is taken.
// ----------------------------------------------------------------------------
module video_block_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic        screen_sel,
	input  logic [1:0]  layer,
	input  logic [15:0] tile_bytes,
	input  logic [1:0]  map_size_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [4:0]  base_index,
	output logic [6:0]  blocks_taken,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_WRITE  = 2'd3;

	localparam int REC_W = $bits(bva_pkg::rec_t);
	localparam int REC_AW = $clog2(bva_pkg::REC_DEPTH);

	logic [1:0]                    state_q;
	logic [bva_pkg::TOP_W-1:0]     tile_search_top_q;
	logic [2:0]                    op_q;
	logic                          scr_q;
	logic [1:0]                    lay_q;
	logic [bva_pkg::CNT_W-1:0]     need_q;
	logic [bva_pkg::SLOTS-1:0]     map_q;
	bva_pkg::rec_t                 rec_q;
	logic                          found_q;
	logic [bva_pkg::CAND_W-1:0]    idx_q;
	logic [bva_pkg::SCREENS-1:0]   slot_vld_q;
	logic [bva_pkg::SCREENS-1:0][bva_pkg::LAYERS-1:0] rec_vld_q;
	logic                          out_valid_q;
	logic                          status_q;
	logic [4:0]                    base_index_q;
	logic [6:0]                    blocks_taken_q;

	logic                          in_beat;
	logic                          out_free;
	logic                          commit;
	logic [bva_pkg::SLOTS-1:0]     map_rdata;
	logic [REC_W-1:0]              rec_rdata;
	logic [bva_pkg::SLOTS-1:0]     map_rd;
	bva_pkg::rec_t                 rec_rd;
	logic [bva_pkg::SLOTS-1:0]     rel_mask;
	logic [bva_pkg::CNT_W-1:0]     need_in;
	logic [bva_pkg::TOP_W-1:0]     top_sat;
	logic                          is_load;
	bva_pkg::srch_ctl_t            srch_ctl;
	bva_pkg::srch_res_t            srch_res;
	logic                          map_we;
	logic [bva_pkg::SLOTS-1:0]     map_wdata;
	logic                          rec_we;
	bva_pkg::rec_t                 rec_wdata;
	logic                          res_status;
	logic [4:0]                    res_base;
	logic [6:0]                    res_taken;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == ST_WRITE) && out_free;
	assign is_load  = (op_q == bva_pkg::OP_LOAD_TILE) || (op_q == bva_pkg::OP_LOAD_MAP);

	// slots needed by the incoming request
	always_comb begin
		if (opcode == bva_pkg::OP_LOAD_MAP) begin
			need_in = bva_pkg::CNT_W'(bva_pkg::MAP_NEED[map_size_code]);
		end else begin
			need_in = bva_pkg::CNT_W'(tile_bytes[15:10]) + bva_pkg::CNT_W'(|tile_bytes[9:0]);
		end
	end

	// search top saturated to the number of bases
	assign top_sat = (tile_search_top_q > bva_pkg::TOP_W'(bva_pkg::NUM_BASES)) ?
		bva_pkg::TOP_W'(bva_pkg::NUM_BASES) : tile_search_top_q;

	// state memories
	bva_ram #(.WIDTH(bva_pkg::SLOTS), .DEPTH(bva_pkg::SCREENS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (scr_q),
		.wdata (map_wdata),
		.re    (in_beat),
		.raddr (screen_sel),
		.rdata (map_rdata)
	);

	bva_ram #(.WIDTH(REC_W), .DEPTH(bva_pkg::REC_DEPTH)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (REC_AW'({scr_q, lay_q})),
		.wdata (rec_wdata),
		.re    (in_beat),
		.raddr (REC_AW'({screen_sel, layer})),
		.rdata (rec_rdata)
	);

	// read data with never-written entries seen as empty
	always_comb begin
		map_rd = slot_vld_q[scr_q] ? map_rdata : '0;
		rec_rd = rec_vld_q[scr_q][lay_q] ? bva_pkg::rec_t'(rec_rdata) : '0;
		if (op_q == bva_pkg::OP_LOAD_TILE || op_q == bva_pkg::OP_DEL_TILE) begin
			rel_mask = bva_pkg::run_mask(
				bva_pkg::SLOT_IW'(rec_rd.tile_base * bva_pkg::SLOTS_PER_BASE),
				rec_rd.tile_slots);
		end else if (op_q == bva_pkg::OP_LOAD_MAP || op_q == bva_pkg::OP_DEL_MAP) begin
			rel_mask = bva_pkg::run_mask(bva_pkg::SLOT_IW'(rec_rd.map_start),
				bva_pkg::CNT_W'(rec_rd.map_slots));
		end else begin
			rel_mask = '0;
		end
	end

	// search unit
	assign srch_ctl = '{
		start:   (state_q == ST_READ) && is_load,
		is_tile: (op_q == bva_pkg::OP_LOAD_TILE),
		need:    need_q,
		top:     top_sat
	};

	bva_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (srch_ctl),
		.map    (map_q),
		.res    (srch_res)
	);

	// write-back and result
	always_comb begin
		map_we     = 1'b0;
		map_wdata  = map_q;
		rec_we     = 1'b0;
		rec_wdata  = rec_q;
		res_status = bva_pkg::STAT_DONE;
		res_base   = '0;
		res_taken  = '0;
		case (op_q)
			bva_pkg::OP_LOAD_TILE: begin
				if (found_q) begin
					map_we    = commit;
					map_wdata = map_q | bva_pkg::run_mask(
						bva_pkg::SLOT_IW'(idx_q * bva_pkg::SLOTS_PER_BASE), need_q);
					rec_we    = commit;
					rec_wdata.tile_base  = bva_pkg::BASE_W'(idx_q);
					rec_wdata.tile_slots = need_q;
					res_base  = 5'(idx_q);
					res_taken = 7'(need_q);
				end else begin
					res_status = bva_pkg::STAT_NO_SPACE;
				end
			end
			bva_pkg::OP_LOAD_MAP: begin
				if (found_q) begin
					map_we    = commit;
					map_wdata = map_q | bva_pkg::run_mask(bva_pkg::SLOT_IW'(idx_q), need_q);
					rec_we    = commit;
					rec_wdata.map_start = bva_pkg::MAP_W'(idx_q);
					rec_wdata.map_slots = 3'(need_q);
					res_base  = 5'(idx_q);
					res_taken = 7'(need_q);
				end else begin
					res_status = bva_pkg::STAT_NO_SPACE;
				end
			end
			bva_pkg::OP_DEL_TILE: begin
				map_we = commit;
				rec_we = commit;
				rec_wdata.tile_base  = '0;
				rec_wdata.tile_slots = '0;
			end
			bva_pkg::OP_DEL_MAP: begin
				map_we = commit;
				rec_we = commit;
				rec_wdata.map_start = '0;
				rec_wdata.map_slots = '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= is_load ? ST_SEARCH : ST_WRITE;
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q   <= opcode;
			scr_q  <= screen_sel;
			lay_q  <= layer;
			need_q <= need_in;
		end
		if (state_q == ST_READ) begin
			map_q <= map_rd & ~rel_mask;
			rec_q <= rec_rd;
		end
		if (state_q == ST_SEARCH && srch_res.done) begin
			found_q <= srch_res.found;
			idx_q   <= srch_res.idx;
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rec_vld_q  <= '0;
		end else if (commit) begin
			if (op_q == bva_pkg::OP_RESET) begin
				slot_vld_q[scr_q] <= 1'b0;
				rec_vld_q[scr_q]  <= '0;
			end else begin
				if (map_we) begin
					slot_vld_q[scr_q] <= 1'b1;
				end
				if (rec_we) begin
					rec_vld_q[scr_q][lay_q] <= 1'b1;
				end
			end
		end
	end

	// search top register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_search_top_q <= bva_pkg::TOP_W'(8);
		end else if (cfg_wr_en) begin
			tile_search_top_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q       <= res_status;
			base_index_q   <= res_base;
			blocks_taken_q <= res_taken;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign base_index   = base_index_q;
	assign blocks_taken = blocks_taken_q;

`ifndef ASSERT_OFF
	a_out_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WRITE))
		else $error("result beat raised outside write-back");

	a_search_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == ST_SEARCH))
		else $error("search answer outside search state");

	a_no_space_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == bva_pkg::STAT_NO_SPACE) |->
		(base_index_q == '0 && blocks_taken_q == '0))
		else $error("no-space result carries an allocation");

	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (blocks_taken_q <= 7'(bva_pkg::SLOTS)))
		else $error("more slots taken than the map holds");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_READ))
		else $error("accepted beat did not start a read");
`endif

endmodule
